// ===== rtl/pipeo_pkg.sv =====
package pipeo_pkg;

  // Coordinate width of the input words; it fixes the struct fields.
  localparam int COORD_BITS = 16;
  // Translated coordinates, their differences and the cross products.
  localparam int TW = COORD_BITS + 1;
  localparam int DW = TW + 1;
  localparam int PW = 2 * DW;

  localparam int MAX_VERTICES_DEF = 64;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;

  localparam logic [1:0] ORI_ZERO = 2'd0;
  localparam logic [1:0] ORI_POS  = 2'd1;
  localparam logic [1:0] ORI_NEG  = 2'd2;

  typedef struct packed {
    logic [1:0]                   op;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
  } in_word_t;

  typedef struct packed {
    logic inside_res;
    logic truncated;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ori_ctl_t;

endpackage

// ===== rtl/point_in_polygon_even_odd_unit.sv =====
// Channel   Ports                          Handshake
// input     start, busy, in_data           taken when start is high and busy low
// result    out_valid, out_data            one-cycle strobe, receiver cannot stall
//
// Clear and append words are taken while idle and leave busy low.
// A test first walks the stored vertices and edges (one memory read a cycle
// into the two-stage orientation unit), then, unless the walk settles the
// answer, scans the vertices with an orientation pass per edge that crosses
// the axis, paced by the single read port of the vertex memory.
// Reset is synchronous and empties the store; the memory itself is not cleared.
module point_in_polygon_even_odd_unit #(
  parameter int MAX_VERTICES = pipeo_pkg::MAX_VERTICES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  pipeo_pkg::in_word_t  in_data,
  output logic                 out_valid,
  output pipeo_pkg::out_word_t out_data
);
  import pipeo_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_WDRAIN = 3'd2;
  localparam logic [2:0] S_SRD    = 3'd3;
  localparam logic [2:0] S_SREG   = 3'd4;
  localparam logic [2:0] S_SEVAL  = 3'd5;
  localparam logic [2:0] S_CROSS  = 3'd6;
  localparam logic [2:0] S_CWAIT  = 3'd7;

  function automatic logic segs_meet(input logic [1:0] o11, input logic [1:0] o12,
                                     input logic [1:0] o21, input logic [1:0] o22);
    logic n1, n2, z;
    n1 = (o11 == ORI_POS && o12 == ORI_NEG) || (o11 == ORI_NEG && o12 == ORI_POS);
    n2 = (o21 == ORI_POS && o22 == ORI_NEG) || (o21 == ORI_NEG && o22 == ORI_POS);
    z  = (o11 == ORI_ZERO) || (o12 == ORI_ZERO) || (o21 == ORI_ZERO) ||
         (o22 == ORI_ZERO);
    segs_meet = (n1 && n2) || z;
  endfunction

  logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] rd_x_r, rd_y_r;
  logic [AW-1:0]                rd_addr, succ_cur;
  logic                         mem_we;

  logic [2:0]   state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, seen_r, seen_nxt;
  logic         drop_r, drop_nxt;
  logic signed [COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [AW-1:0] idx_r, idx_nxt, cur_r, cur_nxt, start_r, start_nxt;

  // Walk pipeline: memory read stage, then translated vertex stage.
  logic          rv_r, rl_r, rk0_r, tv_r, tl_r, tk0_r, close_r;
  logic [AW-1:0] ridx_r, tidx_r;
  logic signed [TW-1:0] tx_r, ty_r;

  logic signed [TW-1:0] prevx_r, prevx_nxt, prevy_r, prevy_nxt;
  logic signed [TW-1:0] firstx_r, firstx_nxt, firsty_r, firsty_nxt;
  logic signed [TW-1:0] sx_r, sx_nxt, sy_r, sy_nxt, ex_r, ex_nxt, ey_r, ey_nxt;
  logic signed [TW-1:0] xmin_r, xmin_nxt, xmax_r, xmax_nxt, sega_r, sega_nxt;
  logic         hit_r, hit_nxt, have_r, have_nxt;
  logic         grp_new_r, grp_new_nxt, savedpos_r, savedpos_nxt;
  logic         parity_r, parity_nxt;
  logic [1:0]   oc_r, oc_nxt, rc_r, rc_nxt;
  logic [1:0]   codes_r [3];
  logic         codes_we;
  logic         out_valid_r, out_valid_nxt;
  out_word_t    out_data_r, out_data_nxt;

  ori_ctl_t             ori_in, ori_out;
  logic [1:0]           ori_code;
  logic signed [TW-1:0] oax, oay, obx, oby, ocx, ocy;

  logic tx_pos, savedpos_eff, meet;

  assign succ_cur = ((CW'(cur_r) + CW'(1)) >= count_r) ? '0 : cur_r + AW'(1);
  assign rd_addr  = (state_r == S_WALK) ? idx_r : succ_cur;
  assign tx_pos   = !tx_r[TW-1] && (tx_r != '0);
  assign savedpos_eff = grp_new_r ? tx_pos : savedpos_r;
  assign meet = segs_meet(codes_r[0], codes_r[1], codes_r[2], ori_code);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[count_r[AW-1:0]] <= in_data.x_coord;
      mem_y[count_r[AW-1:0]] <= in_data.y_coord;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  always_comb begin
    ori_in.valid = (tv_r && !tk0_r) || close_r || (state_r == S_CROSS);
    ori_in.last  = close_r || (state_r == S_CROSS && oc_r == 2'd3);
    if (state_r == S_CROSS) begin
      // Segment s-e against the axis segment from A = (sega, 0) to B = (xmax, 0).
      case (oc_r)
        2'd0: begin
          oax = sx_r; oay = sy_r; obx = ex_r; oby = ey_r; ocx = sega_r; ocy = '0;
        end
        2'd1: begin
          oax = sx_r; oay = sy_r; obx = ex_r; oby = ey_r; ocx = xmax_r; ocy = '0;
        end
        2'd2: begin
          oax = sega_r; oay = '0; obx = xmax_r; oby = '0; ocx = sx_r; ocy = sy_r;
        end
        default: begin
          oax = sega_r; oay = '0; obx = xmax_r; oby = '0; ocx = ex_r; ocy = ey_r;
        end
      endcase
    end else begin
      // Edge from the previous vertex to this one, seen from the test point.
      oax = prevx_r;
      oay = prevy_r;
      obx = close_r ? firstx_r : tx_r;
      oby = close_r ? firsty_r : ty_r;
      ocx = '0;
      ocy = '0;
    end
  end

  pipeo_orient u_orient (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (ori_in),
    .ax       (oax),
    .ay       (oay),
    .bx       (obx),
    .by       (oby),
    .cx       (ocx),
    .cy       (ocy),
    .out_ctl  (ori_out),
    .out_code (ori_code)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    seen_nxt      = seen_r;
    start_nxt     = start_r;
    prevx_nxt     = prevx_r;
    prevy_nxt     = prevy_r;
    firstx_nxt    = firstx_r;
    firsty_nxt    = firsty_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    xmin_nxt      = xmin_r;
    xmax_nxt      = xmax_r;
    sega_nxt      = sega_r;
    hit_nxt       = hit_r;
    have_nxt      = have_r;
    grp_new_nxt   = grp_new_r;
    savedpos_nxt  = savedpos_r;
    parity_nxt    = parity_r;
    oc_nxt        = oc_r;
    rc_nxt        = rc_r;
    codes_we      = 1'b0;
    mem_we        = 1'b0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    // Vertex stage of the walk: vertex hit, axis start, x range, edge feed.
    if (tv_r) begin
      if (tx_r == '0 && ty_r == '0) begin
        hit_nxt = 1'b1;
      end
      if (ty_r != '0) begin
        have_nxt  = 1'b1;
        start_nxt = tidx_r;
        sx_nxt    = tx_r;
        sy_nxt    = ty_r;
      end
      if (tx_r > xmax_r) begin
        xmax_nxt = tx_r;
      end
      if (tx_r < xmin_r) begin
        xmin_nxt = tx_r;
      end
      prevx_nxt = tx_r;
      prevy_nxt = ty_r;
      if (tk0_r) begin
        firstx_nxt = tx_r;
        firsty_nxt = ty_r;
      end
    end
    if (ori_out.valid && ori_code == ORI_ZERO &&
        (state_r == S_WALK || state_r == S_WDRAIN)) begin
      hit_nxt = 1'b1;
    end
    if (ori_out.valid && (state_r == S_CROSS || state_r == S_CWAIT)) begin
      codes_we = 1'b1;
      rc_nxt   = rc_r + 2'd1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_data.op)
            OP_CLEAR: begin
              count_nxt = '0;
              drop_nxt  = 1'b0;
            end
            OP_APPEND: begin
              if (count_r < CW'(MAX_VERTICES)) begin
                mem_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            OP_TEST: begin
              px_nxt   = in_data.x_coord;
              py_nxt   = in_data.y_coord;
              hit_nxt  = 1'b0;
              have_nxt = 1'b0;
              xmin_nxt = '0;
              xmax_nxt = '0;
              idx_nxt  = '0;
              if (count_r == '0) begin
                out_valid_nxt           = 1'b1;
                out_data_nxt.inside_res = 1'b0;
                out_data_nxt.truncated  = drop_r;
              end else begin
                state_nxt = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        idx_nxt = idx_r + AW'(1);
        if ((CW'(idx_r) + CW'(1)) == count_r) begin
          state_nxt = S_WDRAIN;
        end
      end
      S_WDRAIN: begin
        // The closing edge carries the last mark; all walk results are in then.
        if (ori_out.valid && ori_out.last) begin
          if (hit_r || ori_code == ORI_ZERO) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.inside_res = 1'b1;
            out_data_nxt.truncated  = drop_r;
            state_nxt               = S_IDLE;
          end else if (!have_r) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.inside_res = 1'b0;
            out_data_nxt.truncated  = drop_r;
            state_nxt               = S_IDLE;
          end else begin
            cur_nxt     = start_r;
            seen_nxt    = '0;
            grp_new_nxt = 1'b1;
            parity_nxt  = 1'b0;
            state_nxt   = S_SRD;
          end
        end
      end
      S_SRD: begin
        cur_nxt   = succ_cur;
        seen_nxt  = seen_r + CW'(1);
        state_nxt = S_SREG;
      end
      S_SREG: begin
        state_nxt = S_SEVAL;
      end
      S_SEVAL: begin
        if (ty_r == '0) begin
          // Vertex on the axis: the run of such vertices goes on.
          if (grp_new_r) begin
            savedpos_nxt = tx_pos;
          end
          grp_new_nxt = 1'b0;
          state_nxt   = S_SRD;
        end else if ((sy_r[TW-1] != ty_r[TW-1]) && (grp_new_r || savedpos_eff)) begin
          sega_nxt  = grp_new_r ? '0 : xmin_r;
          ex_nxt    = tx_r;
          ey_nxt    = ty_r;
          oc_nxt    = '0;
          rc_nxt    = '0;
          state_nxt = S_CROSS;
        end else begin
          sx_nxt      = tx_r;
          sy_nxt      = ty_r;
          grp_new_nxt = 1'b1;
          if (seen_r == count_r) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.inside_res = parity_r;
            out_data_nxt.truncated  = drop_r;
            state_nxt               = S_IDLE;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      S_CROSS: begin
        oc_nxt = oc_r + 2'd1;
        if (oc_r == 2'd3) begin
          state_nxt = S_CWAIT;
        end
      end
      S_CWAIT: begin
        if (ori_out.valid && ori_out.last) begin
          parity_nxt  = parity_r ^ meet;
          sx_nxt      = ex_r;
          sy_nxt      = ey_r;
          grp_new_nxt = 1'b1;
          if (seen_r == count_r) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.inside_res = parity_r ^ meet;
            out_data_nxt.truncated  = drop_r;
            state_nxt               = S_IDLE;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      drop_r      <= 1'b0;
      rv_r        <= 1'b0;
      tv_r        <= 1'b0;
      close_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      rv_r        <= (state_r == S_WALK);
      tv_r        <= rv_r;
      close_r     <= tv_r && tl_r;
      out_valid_r <= out_valid_nxt;
    end
    rl_r       <= (CW'(idx_r) + CW'(1)) == count_r;
    rk0_r      <= (idx_r == '0);
    ridx_r     <= idx_r;
    tl_r       <= rl_r;
    tk0_r      <= rk0_r;
    tidx_r     <= ridx_r;
    tx_r       <= TW'(rd_x_r) - TW'(px_r);
    ty_r       <= TW'(rd_y_r) - TW'(py_r);
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    idx_r      <= idx_nxt;
    cur_r      <= cur_nxt;
    seen_r     <= seen_nxt;
    start_r    <= start_nxt;
    prevx_r    <= prevx_nxt;
    prevy_r    <= prevy_nxt;
    firstx_r   <= firstx_nxt;
    firsty_r   <= firsty_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    ex_r       <= ex_nxt;
    ey_r       <= ey_nxt;
    xmin_r     <= xmin_nxt;
    xmax_r     <= xmax_nxt;
    sega_r     <= sega_nxt;
    hit_r      <= hit_nxt;
    have_r     <= have_nxt;
    grp_new_r  <= grp_new_nxt;
    savedpos_r <= savedpos_nxt;
    parity_r   <= parity_nxt;
    oc_r       <= oc_nxt;
    rc_r       <= rc_nxt;
    if (codes_we && rc_r != 2'd3) begin
      codes_r[rc_r] <= ori_code;
    end
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/pipeo_orient.sv =====
module pipeo_orient (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pipeo_pkg::ori_ctl_t             in_ctl,
  input  logic signed [pipeo_pkg::TW-1:0] ax,
  input  logic signed [pipeo_pkg::TW-1:0] ay,
  input  logic signed [pipeo_pkg::TW-1:0] bx,
  input  logic signed [pipeo_pkg::TW-1:0] by,
  input  logic signed [pipeo_pkg::TW-1:0] cx,
  input  logic signed [pipeo_pkg::TW-1:0] cy,
  output pipeo_pkg::ori_ctl_t             out_ctl,
  output logic [1:0]                      out_code
);
  import pipeo_pkg::*;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic is_pos(input logic signed [DW-1:0] v);
    is_pos = !v[DW-1] && (v != '0);
  endfunction

  logic signed [DW-1:0] dx1, dy1, dx2, dy2;
  logic signed [PW-1:0] l_nxt, r_nxt, l_r, r_r;
  logic                 opp_nxt, ge_nxt, opp_r, ge_r;
  ori_ctl_t             ctl1_r, ctl2_r;
  logic [1:0]           code_nxt, code_r;

  assign dx1 = DW'(bx) - DW'(ax);
  assign dy1 = DW'(by) - DW'(ay);
  assign dx2 = DW'(cx) - DW'(ax);
  assign dy2 = DW'(cy) - DW'(ay);

  assign l_nxt = dx1 * dy2;
  assign r_nxt = dx2 * dy1;

  // Collinear vectors pointing against each other along either axis.
  assign opp_nxt = (dx1[DW-1] && is_pos(dx2)) || (is_pos(dx1) && dx2[DW-1]) ||
                   (dy1[DW-1] && is_pos(dy2)) || (is_pos(dy1) && dy2[DW-1]);
  // For collinear vectors in the same direction, comparing lengths reduces to
  // comparing each component's magnitude.
  assign ge_nxt = (mag(dx1) >= mag(dx2)) && (mag(dy1) >= mag(dy2));

  always_comb begin
    if (l_r > r_r) begin
      code_nxt = ORI_POS;
    end else if (l_r < r_r) begin
      code_nxt = ORI_NEG;
    end else if (opp_r) begin
      code_nxt = ORI_NEG;
    end else if (ge_r) begin
      code_nxt = ORI_ZERO;
    end else begin
      code_nxt = ORI_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= in_ctl;
      ctl2_r <= ctl1_r;
    end
    l_r    <= l_nxt;
    r_r    <= r_nxt;
    opp_r  <= opp_nxt;
    ge_r   <= ge_nxt;
    code_r <= code_nxt;
  end

  assign out_ctl  = ctl2_r;
  assign out_code = code_r;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import pipeo_pkg::*;

  localparam int NVERT = MAX_VERTICES_DEF;
  localparam int IDLE_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_data = '0;
  logic      out_valid;
  out_word_t out_data;

  point_in_polygon_even_odd_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the polygon store.
  longint    poly_x[NVERT];
  longint    poly_y[NVERT];
  int        poly_n = 0;
  bit        poly_dropped = 1'b0;
  out_word_t answers_due[$];
  int        fail_count = 0;
  int        quiet_cycles = 0;

  // A typed-in answer travels with the word that is being driven.
  bit        typed_on = 1'b0;
  out_word_t typed_word = '0;

  function automatic int wrap_next(int n, int k);
    return (k + 1 >= n) ? 0 : k + 1;
  endfunction

  function automatic int turn_sign(longint ax, longint ay, longint bx, longint by,
                                   longint cx, longint cy);
    longint dx1, dy1, dx2, dy2, l, r;
    longint unsigned d1, d2;
    dx1 = bx - ax; dy1 = by - ay;
    dx2 = cx - ax; dy2 = cy - ay;
    l = dx1 * dy2; r = dx2 * dy1;
    if (l > r) return 1;
    if (l < r) return -1;
    if ((dx1 < 0 && dx2 > 0) || (dx1 > 0 && dx2 < 0) ||
        (dy1 < 0 && dy2 > 0) || (dy1 > 0 && dy2 < 0))
      return -1;
    d1 = longint'(dx1 * dx1) + longint'(dy1 * dy1);
    d2 = longint'(dx2 * dx2) + longint'(dy2 * dy2);
    return (d1 >= d2) ? 0 : 1;
  endfunction

  function automatic bit segments_touch(longint ax, longint ay, longint bx, longint by,
                                        longint cx, longint cy, longint dx, longint dy);
    int o11, o12, o21, o22;
    o11 = turn_sign(ax, ay, bx, by, cx, cy);
    o12 = turn_sign(ax, ay, bx, by, dx, dy);
    o21 = turn_sign(cx, cy, dx, dy, ax, ay);
    o22 = turn_sign(cx, cy, dx, dy, bx, by);
    if (o11 * o12 < 0 && o21 * o22 < 0) return 1'b1;
    return (o11 * o12 * o21 * o22 == 0);
  endfunction

  function automatic bit point_enclosed(longint px, longint py);
    int n, cur, seen, saved, j, first;
    bit parity, have_first;
    longint xmin, xmax, sx, sy, ex, ey, savedx, tx, ty;
    n = poly_n; parity = 0; have_first = 0; first = 0;
    xmin = 0; xmax = 0; sx = 0; sy = 0;
    for (int k = 0; k < n; k++) begin
      tx = poly_x[k] - px; ty = poly_y[k] - py;
      if (tx == 0 && ty == 0) return 1'b1;
      if (ty != 0) begin
        sx = tx; sy = ty; first = k; have_first = 1;
      end
      if (tx > xmax) xmax = tx;
      if (tx < xmin) xmin = tx;
    end
    for (int k = 0; k < n; k++) begin
      j = wrap_next(n, k);
      if (segments_touch(0, 0, 0, 0, poly_x[k] - px, poly_y[k] - py,
                         poly_x[j] - px, poly_y[j] - py))
        return 1'b1;
    end
    if (!have_first) return 1'b0;
    cur = first; seen = 0;
    while (seen < n) begin
      saved = wrap_next(n, cur);
      savedx = poly_x[saved] - px;
      do begin
        cur = wrap_next(n, cur);
        seen++;
      end while (poly_y[cur] - py == 0);
      ex = poly_x[cur] - px; ey = poly_y[cur] - py;
      if ((sy < 0 && ey > 0) || (sy > 0 && ey < 0)) begin
        if (cur == saved)
          parity ^= segments_touch(sx, sy, ex, ey, 0, 0, xmax, 0);
        else if (savedx > 0)
          parity ^= segments_touch(sx, sy, ex, ey, xmin, 0, xmax, 0);
      end
      sx = ex; sy = ey;
    end
    return parity;
  endfunction

  // Predict on every accepted word and check every result strobe.
  always @(posedge clk) begin
    out_word_t want, got;
    bit        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (start && !busy) begin
        moved = 1'b1;
        case (in_data.op)
          OP_CLEAR: begin
            poly_n = 0; poly_dropped = 0;
          end
          OP_APPEND: begin
            if (poly_n < NVERT) begin
              poly_x[poly_n] = longint'(in_data.x_coord);
              poly_y[poly_n] = longint'(in_data.y_coord);
              poly_n++;
            end else begin
              poly_dropped = 1;
            end
          end
          OP_TEST: begin
            want.inside_res = point_enclosed(longint'(in_data.x_coord),
                                             longint'(in_data.y_coord));
            want.truncated = poly_dropped;
            if (typed_on) want = typed_word;
            answers_due = {answers_due, want};
          end
          default: ;
        endcase
      end
      if (out_valid) begin
        moved = 1'b1;
        got = out_data;
        if (answers_due.size() == 0) begin
          $error("result word with no answer due");
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (got.inside_res !== want.inside_res) begin
            $error("inside_res expected %0d actual %0d", want.inside_res, got.inside_res);
            fail_count++;
          end
          if (got.truncated !== want.truncated) begin
            $error("truncated expected %0d actual %0d", want.truncated, got.truncated);
            fail_count++;
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  int  word_index = 0;
  bit  calm_stretch = 0;

  task automatic send_word(logic [1:0] op, int x, int y, bit typed = 0,
                           bit enclosed = 0, bit trunc = 0);
    int gap;
    if (!calm_stretch && $urandom_range(99) < 20) begin
      start <= 1'b0;
      gap = $urandom_range(6, 1);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_data <= '{op: op, x_coord: x[15:0], y_coord: y[15:0]};
    typed_on <= typed;
    typed_word <= '{inside_res: enclosed, truncated: trunc};
    @(negedge clk);
    while (busy) @(negedge clk);
    word_index++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    typed_on <= 1'b0;
    @(negedge clk);
    while (answers_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  typedef struct {
    logic [1:0] op;
    int         x;
    int         y;
    bit         typed;
    bit         enclosed;
    bit         trunc;
  } row_t;

  row_t directed[] = '{
    '{OP_TEST,   0,      0,      1, 0, 0},   // empty polygon
    '{OP_TEST,   32767,  -32768, 1, 0, 0},
    '{2'd3,      -1,     -1,     0, 0, 0},   // unused op is ignored
    '{OP_APPEND, -32768, -32768, 0, 0, 0},
    '{OP_APPEND, 32767,  -32768, 0, 0, 0},
    '{OP_APPEND, 32767,  32767,  0, 0, 0},
    '{OP_APPEND, -32768, 32767,  0, 0, 0},
    '{OP_TEST,   -32768, -32768, 1, 1, 0},   // on a vertex
    '{OP_TEST,   0,      -32768, 1, 1, 0},   // on an edge
    '{OP_TEST,   0,      0,      0, 0, 0},
    '{OP_TEST,   32767,  0,      0, 0, 0},
    '{OP_CLEAR,  0,      0,      0, 0, 0},
    '{OP_APPEND, -5,     3,      0, 0, 0},   // all on one horizontal line
    '{OP_APPEND, 0,      3,      0, 0, 0},
    '{OP_APPEND, 7,      3,      0, 0, 0},
    '{OP_TEST,   20,     3,      1, 0, 0},
    '{OP_TEST,   2,      3,      0, 0, 0},
    '{OP_APPEND, 7,      3,      0, 0, 0},   // repeated vertex
    '{OP_APPEND, 0,      -9,     0, 0, 0},
    '{OP_TEST,   1,      0,      0, 0, 0},
    '{OP_TEST,   -20,    -1,     0, 0, 0},
    '{OP_CLEAR,  0,      0,      0, 0, 0},
    '{OP_TEST,   0,      0,      1, 0, 0}
  };

  task automatic small_coord(output int v, input int span);
    v = $urandom_range(2 * span) - span;
  endtask

  initial begin
    int nv, nt, x, y, span, k;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i])
      send_word(directed[i].op, directed[i].x, directed[i].y,
                directed[i].typed, directed[i].enclosed, directed[i].trunc);
    // Overfill the store so that the truncated flag rises and sticks.
    for (int i = 0; i < NVERT + 2; i++)
      send_word(OP_APPEND, $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
    send_word(OP_TEST, 0, 0);
    send_word(OP_APPEND, 1, 1);
    send_word(OP_TEST, 1, 1);
    wait_drained();

    while (word_index < 1850) begin
      calm_stretch = (word_index > 900 && word_index < 1150);
      if ($urandom_range(99) < 10) begin
        // Noise: any op, any coordinates.
        send_word(2'($urandom_range(3)), $urandom_range(65535) - 32768,
                  $urandom_range(65535) - 32768);
        continue;
      end
      span = ($urandom_range(9) == 0) ? 32767 : (($urandom_range(1)) ? 6 : 40);
      if ($urandom_range(1)) send_word(OP_CLEAR, $urandom_range(65535) - 32768,
                                       $urandom_range(65535) - 32768);
      nv = ($urandom_range(29) == 0) ? $urandom_range(NVERT + 4, NVERT - 2)
                                     : $urandom_range(10, 1);
      for (int i = 0; i < nv; i++) begin
        small_coord(x, span); small_coord(y, span);
        send_word(OP_APPEND, x, y);
      end
      nt = $urandom_range(8, 2);
      for (int i = 0; i < nt; i++) begin
        if (poly_n > 0 && $urandom_range(3) == 0) begin
          k = $urandom_range(poly_n - 1);
          x = int'(poly_x[k]) + $urandom_range(2) - 1;
          y = int'(poly_y[k]) + $urandom_range(2) - 1;
          if (x > 32767) x = 32767;
          if (x < -32768) x = -32768;
          if (y > 32767) y = 32767;
          if (y < -32768) y = -32768;
        end else begin
          small_coord(x, span); small_coord(y, span);
        end
        send_word(OP_TEST, x, y);
      end
      if ($urandom_range(15) == 0) wait_drained();
    end

    wait_drained();
    repeat (700) @(negedge clk);
    if (fail_count == 0 && answers_due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
